@@ design/rmts_pkg.sv @@
// ----------------------------------------------------------------------------
// rmts_pkg
// Shared types and constants of the rate-monotonic task scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
package rmts_pkg;
	localparam int MaxTasks  = 16;
	localparam int SlotW     = $clog2(MaxTasks);
	localparam int UtilScale = 10000;
	localparam int PidW      = 22;
	localparam int PerW      = 16;
	localparam int UtilW     = 14;
	localparam int TimeW     = 32;
	localparam int NumW      = 30;   // cost*scale fits in 30 bits
	localparam int QW        = NumW; // full quotient width for the admission compare

	localparam logic [UtilW-1:0] UtilLimitRst = 14'd6930;

	localparam logic [1:0] OP_REG   = 2'd0;
	localparam logic [1:0] OP_YIELD = 2'd1;
	localparam logic [1:0] OP_DEREG = 2'd2;
	localparam logic [1:0] OP_TICK  = 2'd3;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_REFUSED = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_NOTFND  = 3'd3;
	localparam logic [2:0] ST_ZEROPER = 3'd4;

	localparam logic [1:0] MODE_RUN   = 2'd0;
	localparam logic [1:0] MODE_READY = 2'd1;
	localparam logic [1:0] MODE_SLEEP = 2'd2;

	typedef struct packed {
		logic [1:0]      operation;
		logic [PidW-1:0] task_pid;
		logic [PerW-1:0] task_period;
		logic [PerW-1:0] task_cost;
	} req_t;

	typedef struct packed {
		logic [2:0]       status;
		logic             running_valid;
		logic [PidW-1:0]  running_pid;
		logic             switched;
		logic [UtilW-1:0] util_now;
	} rsp_t;

	// token passed along the chain of cells during a scan
	typedef struct packed {
		logic             found;     // first matching pid seen
		logic             cand_v;    // ready candidate
		logic [SlotW-1:0] cand;
		logic [PerW-1:0]  cand_per;
	} tok_t;

	// slot state seen by the controller
	typedef struct packed {
		logic             used;
		logic [PidW-1:0]  ident;
		logic [PerW-1:0]  period;
		logic [UtilW-1:0] share;
		logic [1:0]       mode;
		logic             started;
		logic [TimeW-1:0] deadline;
	} slot_t;
endpackage
`default_nettype wire

@@ design/rmts_if.sv @@
// ----------------------------------------------------------------------------
// rmts_req_if / rmts_rsp_if
// Valid/ready channels of the scheduler.
// ----------------------------------------------------------------------------
`default_nettype none
interface rmts_req_if;
	logic valid;
	logic ready;
	rmts_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface rmts_rsp_if;
	logic valid;
	logic ready;
	rmts_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ design/rate_monotonic_task_scheduler.sv @@
// Each item makes three passes over the slot ring (find/apply, candidate,
// dispatch) and then a registered output stage; a registration that
// reaches the admission check runs the 30-step divide between the first two.
// An item is taken only in the idle state; the next item is taken
// while a result waits, and a stalled result holds the block at its output.
// Reset (arst_n low) empties all slots, clears time, total and the running
// task, and loads util_limit with 6930.
`default_nettype none
module rate_monotonic_task_scheduler (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [rmts_pkg::UtilW-1:0]  cfg_wdata,
	rmts_req_if.sink                         req,
	rmts_rsp_if.source                       rsp
);
	localparam int N  = rmts_pkg::MaxTasks;
	localparam int SW = rmts_pkg::SlotW;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_P1   = 3'd1; // find pid / free slot, apply op
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_DW   = 3'd3;
	localparam logic [2:0] S_P2   = 3'd4; // find ready candidate
	localparam logic [2:0] S_P3   = 3'd5; // apply dispatch
	localparam logic [2:0] S_OUT  = 3'd6;

	logic [2:0]  st_q;
	logic [SW:0] cnt_q;          // rotation count
	rmts_pkg::req_t  r_q;
	rmts_pkg::tok_t  tok_q;
	rmts_pkg::slot_t ring   [N];
	rmts_pkg::slot_t head_in;     // written back into cell 0
	logic        shift;
	logic [rmts_pkg::UtilW-1:0] limit_q, total_q;
	logic [rmts_pkg::TimeW-1:0] time_q;
	logic        run_v_q, was_v_q, fnd_q;
	logic [SW-1:0] run_s_q, was_s_q, hit_q;
	logic [rmts_pkg::PerW-1:0] run_per_q;
	logic [rmts_pkg::PidW-1:0] run_pid_q;
	logic [2:0]  stat_q;
	logic        dstart, ddone;
	logic [rmts_pkg::NumW-1:0] quo;
	logic        preempt_q;
	logic        rsp_v_q;
	rmts_pkg::rsp_t rsp_q;

	// cell i holds, during a pass, the slot (cnt + N-1 - i) mod N; cell N-1 is
	// the head that the controller inspects, and its update feeds cell 0.
	assign shift = (st_q == S_P1 || st_q == S_P2 || st_q == S_P3);

	for (genvar i = 0; i < N; i++) begin : g_cell
		if (i == 0) begin : g_first
			rmts_cell u_cell (
				.clk(clk), .arst_n(arst_n), .shift(shift),
				.prev(head_in), .cur(ring[i])
			);
		end else begin : g_next
			rmts_cell u_cell (
				.clk(clk), .arst_n(arst_n), .shift(shift),
				.prev(ring[i-1]), .cur(ring[i])
			);
		end
	end

	rmts_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart),
		.num(rmts_pkg::NumW'(r_q.task_cost) * rmts_pkg::NumW'(rmts_pkg::UtilScale)),
		.den(r_q.task_period), .done(ddone), .quo(quo)
	);
	assign dstart = (st_q == S_DIV);

	rmts_pkg::slot_t h;
	logic [SW-1:0] sidx;          // slot number of head
	logic [rmts_pkg::QW:0] tot_sum;
	assign h = ring[N-1];
	assign sidx = cnt_q[SW-1:0];
	assign tot_sum = (rmts_pkg::QW+1)'(total_q) + (rmts_pkg::QW+1)'(quo);

	always_comb begin
		head_in = h;
		case (st_q)
			S_P1: begin
				case (r_q.operation)
					rmts_pkg::OP_YIELD: if (h.used && h.ident == r_q.task_pid && !tok_q.found) begin
						if (!h.started) begin
							head_in.started  = 1'b1;
							head_in.deadline = time_q + rmts_pkg::TimeW'(h.period);
							head_in.mode     = rmts_pkg::MODE_READY;
						end else if (time_q >= h.deadline) begin
							head_in.deadline = h.deadline + rmts_pkg::TimeW'(h.period);
							head_in.mode     = rmts_pkg::MODE_READY;
						end else begin
							head_in.mode = rmts_pkg::MODE_SLEEP;
						end
					end
					rmts_pkg::OP_DEREG: if (h.used && h.ident == r_q.task_pid && !tok_q.found)
						head_in.used = 1'b0;
					rmts_pkg::OP_TICK: if (h.used && h.mode == rmts_pkg::MODE_SLEEP &&
						h.started && (time_q + 1'b1) >= h.deadline)
						head_in.mode = rmts_pkg::MODE_READY;
					default: ;
				endcase
			end
			S_P2: begin
				// second pass also places an admitted registration
				if (r_q.operation == rmts_pkg::OP_REG && stat_q == rmts_pkg::ST_OK &&
					fnd_q && sidx == hit_q) begin
					head_in.used     = 1'b1;
					head_in.ident    = r_q.task_pid;
					head_in.period   = r_q.task_period;
					head_in.share    = rmts_pkg::UtilW'(quo);
					head_in.mode     = rmts_pkg::MODE_SLEEP;
					head_in.started  = 1'b0;
					head_in.deadline = '0;
				end
			end
			S_P3: begin
				if (run_v_q && sidx == run_s_q && h.used)
					head_in.mode = preempt_q ? rmts_pkg::MODE_READY : rmts_pkg::MODE_RUN;
				if (tok_q.cand_v && preempt_q && sidx == tok_q.cand)
					head_in.mode = rmts_pkg::MODE_RUN;
			end
			default: ;
		endcase
	end

	// candidate evaluated on the updated slot content
	logic cand_hit;
	assign cand_hit = head_in.used && head_in.mode == rmts_pkg::MODE_READY &&
		(!tok_q.cand_v || head_in.period < tok_q.cand_per);

	assign req.ready = (st_q == S_IDLE);
	assign rsp.valid = rsp_v_q;
	assign rsp.data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			cnt_q   <= '0;
			limit_q <= rmts_pkg::UtilLimitRst;
			total_q <= '0;
			time_q  <= '0;
			run_v_q <= 1'b0;
			run_s_q <= '0;
			rsp_v_q <= 1'b0;
			tok_q   <= '0;
			fnd_q   <= 1'b0;
		end else begin
			if (cfg_we) limit_q <= cfg_wdata;
			if (rsp_v_q && rsp.ready) rsp_v_q <= 1'b0;
			case (st_q)
				S_IDLE: if (req.valid) begin
					r_q     <= req.data;
					was_v_q <= run_v_q;
					was_s_q <= run_s_q;
					stat_q  <= rmts_pkg::ST_OK;
					tok_q   <= '0;
					fnd_q   <= 1'b0;
					cnt_q   <= '0;
					st_q    <= S_P1;
				end
				S_P1: begin
					if (r_q.operation == rmts_pkg::OP_REG) begin
						if (!h.used && !fnd_q) begin fnd_q <= 1'b1; hit_q <= sidx; end
					end else if (r_q.operation != rmts_pkg::OP_TICK) begin
						if (h.used && h.ident == r_q.task_pid && !fnd_q) begin
							fnd_q <= 1'b1;
							hit_q <= sidx;
							tok_q.found <= 1'b1;
							if (r_q.operation == rmts_pkg::OP_DEREG) begin
								total_q <= total_q - h.share;
								if (run_v_q && run_s_q == sidx) run_v_q <= 1'b0;
							end else if (h.started && time_q < h.deadline &&
								run_v_q && run_s_q == sidx)
								run_v_q <= 1'b0;
						end
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == (SW+1)'(N-1)) begin
						cnt_q <= '0;
						tok_q <= '0;
						if (r_q.operation == rmts_pkg::OP_TICK) time_q <= time_q + 1'b1;
						if (r_q.operation == rmts_pkg::OP_REG) begin
							if (r_q.task_period == '0) begin
								stat_q <= rmts_pkg::ST_ZEROPER; st_q <= S_P2;
							end else if (!(fnd_q || !h.used)) begin
								stat_q <= rmts_pkg::ST_FULL; st_q <= S_P2;
							end else st_q <= S_DIV;
						end else begin
							if (!(fnd_q || (h.used && h.ident == r_q.task_pid)) &&
								r_q.operation != rmts_pkg::OP_TICK)
								stat_q <= rmts_pkg::ST_NOTFND;
							st_q <= S_P2;
						end
					end
				end
				S_DIV: st_q <= S_DW;
				S_DW: if (ddone) begin
					if (tot_sum > (rmts_pkg::QW+1)'(limit_q)) stat_q <= rmts_pkg::ST_REFUSED;
					else total_q <= rmts_pkg::UtilW'(tot_sum);
					st_q <= S_P2;
				end
				S_P2: begin
					if (cand_hit) begin
						tok_q.cand_v   <= 1'b1;
						tok_q.cand     <= sidx;
						tok_q.cand_per <= head_in.period;
					end
					if (run_v_q && sidx == run_s_q) run_per_q <= head_in.period;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == (SW+1)'(N-1)) begin
						cnt_q <= '0;
						st_q  <= S_P3;
						preempt_q <= 1'b0;
						if (run_v_q) begin
							if ((cand_hit || tok_q.cand_v) &&
								(cand_hit ? head_in.period : tok_q.cand_per) <
								((sidx == run_s_q) ? head_in.period : run_per_q))
								preempt_q <= 1'b1;
						end else if (cand_hit || tok_q.cand_v) preempt_q <= 1'b1;
					end
				end
				S_P3: begin
					if (sidx == (preempt_q ? tok_q.cand : run_s_q) &&
						(preempt_q || run_v_q))
						run_pid_q <= h.ident;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == (SW+1)'(N-1)) begin
						if (preempt_q) begin run_v_q <= 1'b1; run_s_q <= tok_q.cand; end
						st_q <= S_OUT;
					end
				end
				S_OUT: if (!rsp_v_q) begin
					rsp_v_q <= 1'b1;
					rsp_q.status        <= stat_q;
					rsp_q.running_valid <= run_v_q;
					rsp_q.running_pid   <= run_v_q ? run_pid_q : '0;
					rsp_q.switched      <= (was_v_q != run_v_q) ||
						(run_v_q && was_s_q != run_s_q);
					rsp_q.util_now      <= total_q;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> st_q == S_IDLE) else $error("ready outside idle");
	a_one_out: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_OUT && !rsp_v_q) |=> rsp_v_q) else $error("result not raised");
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_IDLE) |-> total_q <= rmts_pkg::UtilW'(16383)) else $error("total");
endmodule
`default_nettype wire

@@ design/rmts_div.sv @@
// ----------------------------------------------------------------------------
// rmts_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module rmts_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [rmts_pkg::NumW-1:0] num,
	input  wire logic [rmts_pkg::PerW-1:0] den,
	output logic                           done,
	output logic [rmts_pkg::NumW-1:0]      quo
);
	localparam int CW = $clog2(rmts_pkg::NumW + 1);
	logic [CW-1:0]             cnt_q;
	logic                      busy_q;
	logic [rmts_pkg::NumW-1:0] q_q;
	logic [rmts_pkg::PerW:0]   rem_q;
	logic [rmts_pkg::PerW:0]   trial;
	logic [rmts_pkg::PerW:0]   diff;

	assign trial = {rem_q[rmts_pkg::PerW-1:0], q_q[rmts_pkg::NumW-1]};
	assign diff  = trial - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(rmts_pkg::NumW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num;
			rem_q <= '0;
		end else if (busy_q) begin
			if (!diff[rmts_pkg::PerW]) begin
				rem_q <= diff;
				q_q   <= {q_q[rmts_pkg::NumW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				q_q   <= {q_q[rmts_pkg::NumW-2:0], 1'b0};
			end
		end
	end
	assign quo = q_q;
endmodule
`default_nettype wire

@@ design/rmts_cell.sv @@
// ----------------------------------------------------------------------------
// rmts_cell
// One task slot; slots form a ring that rotates one place per scan cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module rmts_cell (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                shift,
	input  wire rmts_pkg::slot_t     prev,
	output rmts_pkg::slot_t          cur
);
	// ring rotation: each cell takes its neighbor's content
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cur <= '0;
		else if (shift) cur <= prev;
	end
endmodule
`default_nettype wire
